>>> design/assert_macros.svh
// Assertion macros used by the checker of the line minimizer.
// Each macro builds one clocked concurrent assertion that reset disables.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication.
`define BLM_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define BLM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

>>> design/blm_pkg.sv
// Shared types and constants of the Brent line minimizer.
// No dependencies; every module of the design imports this package.
`default_nettype none
package blm_pkg;

  // Result status codes.
  localparam logic [2:0] ST_EVAL     = 3'd0;
  localparam logic [2:0] ST_DONE     = 3'd1;
  localparam logic [2:0] ST_COLLAPSE = 3'd2;
  localparam logic [2:0] ST_BRLIMIT  = 3'd3;
  localparam logic [2:0] ST_ITLIMIT  = 3'd4;
  localparam logic [2:0] ST_INVERTED = 3'd5;
  localparam logic [2:0] ST_IGNORED  = 3'd6;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_SIZE = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWER     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LOWER_EN  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UPPER     = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_UPPER_EN  = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MAXIMIZE  = 3'd6;

  // Golden section and expansion ratios in Q30.
  localparam longint GOLD_Q30    = 64'sd410132881;
  localparam longint EXPGOLD_Q30 = 64'sd1737314271;

  // Working width of sums is WIDE_BASE - FRAC_BITS, product width MUL_BASE - FRAC_BITS.
  localparam int WIDE_BASE = 68;
  localparam int MUL_BASE  = 64;

  typedef struct packed {
    logic        [30:0] tolerance;
    logic        [30:0] step_size;
    logic signed [31:0] lower_bound;
    logic               lower_bound_enable;
    logic signed [31:0] upper_bound;
    logic               upper_bound_enable;
    logic               maximize_mode;
  } blm_cfg_t;

endpackage
`default_nettype wire

>>> design/blm_in_if.sv
// Input channel of the line minimizer: start or function value items.
// Depends on nothing.
`default_nettype none
interface blm_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic signed [31:0] function_value;
  modport source (output valid, mode, function_value, input ready);
  modport sink (input valid, mode, function_value, output ready);
endinterface
`default_nettype wire

>>> design/blm_out_if.sv
// Result channel of the line minimizer: status and point.
// Depends on nothing.
`default_nettype none
interface blm_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic signed [31:0] point;
  modport source (output valid, status, point, input ready);
  modport sink (input valid, status, point, output ready);
endinterface
`default_nettype wire

>>> design/blm_mul.sv
// Shared fixed-point multiplier with a registered product.
// Depends on blm_pkg for the width constants.
`default_nettype none
module blm_mul
  import blm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                 clk,
  input  wire logic signed [WIDE_BASE-FRAC_BITS-1:0] a,
  input  wire logic signed [WIDE_BASE-FRAC_BITS-1:0] b,
  output      logic signed [MUL_BASE-FRAC_BITS-1:0]  r
);
  localparam int WW = WIDE_BASE - FRAC_BITS;
  localparam int MW = MUL_BASE - FRAC_BITS;
  localparam logic signed [WW-1:0] MAXV = {{(WW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [WW-1:0] MINV = {{(WW-31){1'b1}}, {31{1'b0}}};

  function automatic logic signed [31:0] sat32(input logic signed [WW-1:0] x);
    if (x > MAXV) return 32'sh7fffffff;
    if (x < MINV) return 32'sh80000000;
    return x[31:0];
  endfunction

  logic signed [31:0] sa, sb;
  logic        [31:0] ma, mb;
  logic        [63:0] prod;
  logic        [MW-1:0] mag;

  always_comb begin
    sa   = sat32(a);
    sb   = sat32(b);
    ma   = sa[31] ? 32'(-sa) : 32'(sa);
    mb   = sb[31] ? 32'(-sb) : 32'(sb);
    prod = 64'(ma) * 64'(mb);
    mag  = MW'(prod >> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    r <= (sa[31] != sb[31]) ? $signed(-mag) : $signed(mag);
  end
endmodule
`default_nettype wire

>>> design/blm_div.sv
// Bit-serial restoring divider for (p << FRAC_BITS) / q, truncating, saturated.
// Depends on blm_pkg by convention only for the house import.
`default_nettype none
module blm_div
  import blm_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output      logic               done,
  output      logic signed [31:0] quot
);
  localparam int NB = 32 + FRAC_BITS;
  localparam int CW = $clog2(NB + 1);

  logic [NB-1:0] nreg;
  logic [32:0]   rem;
  logic [31:0]   dmag;
  logic          neg;
  logic          busy;
  logic [CW-1:0] cnt;
  logic [32:0]   sh;
  logic          fits;

  always_comb begin
    sh   = {rem[31:0], nreg[NB-1]};
    fits = sh >= {1'b0, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NB);
        rem  <= '0;
        nreg <= {(num[31] ? 32'(-num) : 32'(num)), {FRAC_BITS{1'b0}}};
        dmag <= den[31] ? 32'(-den) : 32'(den);
        neg  <= num[31] != den[31];
      end else if (busy) begin
        rem  <= fits ? (sh - {1'b0, dmag}) : sh;
        nreg <= {nreg[NB-2:0], fits};
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Quotient magnitude saturates to the positive 32-bit range before the sign.
  logic [31:0] qmag;
  always_comb begin
    if (dmag == '0) qmag = '0;
    else if (nreg > NB'(32'h7fffffff)) qmag = 32'h7fffffff;
    else qmag = nreg[31:0];
    quot = neg ? $signed(-qmag) : $signed(qmag);
  end
endmodule
`default_nettype wire

>>> design/blm_seq.sv
// Search sequencer of the line minimizer: phase tracking, bracket and Brent
// state, micro-step control of the shared multiplier and the divider.
// Depends on blm_pkg, blm_in_if, blm_out_if, blm_mul and blm_div.
`default_nettype none
module blm_seq
  import blm_pkg::*;
#(
  parameter int MAX_ROUNDS = 30,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire blm_cfg_t cfg,
  blm_in_if.sink        req,
  blm_out_if.source     rsp
);
  localparam int WW = WIDE_BASE - FRAC_BITS;
  localparam int MW = MUL_BASE - FRAC_BITS;
  localparam logic signed [WW-1:0] MAXV = {{(WW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [WW-1:0] MINV = {{(WW-31){1'b1}}, {31{1'b0}}};
  localparam logic signed [WW-1:0] GOLD = WW'(GOLD_Q30 >>> (30 - FRAC_BITS));
  localparam logic signed [WW-1:0] EXPG = WW'(EXPGOLD_Q30 >>> (30 - FRAC_BITS));
  localparam logic signed [WW-1:0] ONE  = WW'(64'sd1 <<< FRAC_BITS);

  // Search phases.
  localparam logic [3:0] PH_IDLE = 4'd0, PH_BR_L = 4'd1, PH_BR_R = 4'd2, PH_BR_M = 4'd3;
  localparam logic [3:0] PH_NEW_R = 4'd4, PH_NEW_L = 4'd5, PH_NEW_M = 4'd6;
  localparam logic [3:0] PH_INIT_W = 4'd7, PH_INIT_M = 4'd8, PH_ITER = 4'd9;

  // Micro steps.
  localparam logic [4:0] S_IDLE = 5'd0, S_DISP = 5'd1, S_BRR1 = 5'd2, S_CHK1 = 5'd3;
  localparam logic [4:0] S_BODY0 = 5'd4, S_BODY1 = 5'd5, S_IT1 = 5'd6, S_IT2 = 5'd7;
  localparam logic [4:0] S_P0 = 5'd8, S_P1 = 5'd9, S_P2 = 5'd10, S_P3 = 5'd11;
  localparam logic [4:0] S_P4 = 5'd12, S_P5 = 5'd13, S_P6 = 5'd14, S_P7 = 5'd15;
  localparam logic [4:0] S_P8 = 5'd16, S_P9 = 5'd17, S_DIVW = 5'd18, S_GOLD0 = 5'd19;
  localparam logic [4:0] S_GOLD1 = 5'd20, S_FIN = 5'd21;

  // Bracket moves.
  localparam logic [1:0] BC_INIT = 2'd0, BC_R = 2'd1, BC_M = 2'd2, BC_L = 2'd3;

  function automatic logic signed [31:0] sat32(input logic signed [WW-1:0] x);
    if (x > MAXV) return 32'sh7fffffff;
    if (x < MINV) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [WW-1:0] ext(input logic signed [31:0] x);
    return WW'(x);
  endfunction

  function automatic logic signed [WW-1:0] absw(input logic signed [WW-1:0] x);
    return x[WW-1] ? -x : x;
  endfunction

  // Halving that truncates toward zero.
  function automatic logic signed [WW-1:0] half(input logic signed [WW-1:0] x);
    logic signed [WW-1:0] adj;
    adj = $signed({{(WW-1){1'b0}}, x[WW-1] & x[0]});
    return (x + adj) >>> 1;
  endfunction

  logic [4:0] st;
  logic [3:0] phase;
  logic       ov;
  logic [2:0] ost;
  logic signed [31:0] opt;
  logic signed [31:0] lp, mp, rp, lv, mv, rv, wp, wv, vp, vv, dn, eb, pp, fin;
  logic [7:0] rc;
  logic       mode_r;
  logic [1:0] bcase, bc;
  logic       c1, c2;
  logic signed [WW-1:0] ta, tb, tc, tp, tq, tt;

  logic signed [WW-1:0] mul_a, mul_b;
  logic signed [MW-1:0] mr;
  logic signed [WW-1:0] mrw;
  logic                 div_start, div_done;
  logic signed [31:0]   dq;

  logic signed [WW-1:0] tolw, wl, wu, ma, eg, body_x, body_xc;
  logic                 lt;

  assign mrw  = WW'(mr);
  assign tolw = $signed(WW'(cfg.tolerance));

  blm_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (.clk(clk), .a(mul_a), .b(mul_b), .r(mr));

  blm_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num(sat32(tp)), .den(sat32(tq)), .done(div_done), .quot(dq)
  );

  assign req.ready = (st == S_IDLE) && !ov;
  assign rsp.valid  = ov;
  assign rsp.status = ost;
  assign rsp.point  = opt;

  always_comb begin
    wl = ext(mp) - ext(lp);
    wu = ext(rp) - ext(mp);
    lt = (ext(mp) <<< 1) < (ext(lp) + ext(rp));
    eg = lt ? wu : -wl;
    if (lp < 0 && rp > 0) ma = '0;
    else if (absw(ext(lp)) < absw(ext(rp))) ma = absw(ext(lp));
    else ma = absw(ext(rp));

    if (mv < lv) begin
      if (mv < rv) bc = BC_INIT;
      else if (mv > rv) bc = (cfg.upper_bound_enable && rp == cfg.upper_bound) ? BC_INIT : BC_R;
      else bc = BC_M;
    end else begin
      bc = (cfg.lower_bound_enable && lp == cfg.lower_bound) ? BC_INIT : BC_L;
    end

    body_x  = ((bcase == BC_R) ? ext(rp) : ext(lp)) + mrw;
    body_xc = body_x;
    if (bcase == BC_R && cfg.upper_bound_enable && body_x > ext(cfg.upper_bound))
      body_xc = ext(cfg.upper_bound);
    if (bcase == BC_L && cfg.lower_bound_enable && body_x < ext(cfg.lower_bound))
      body_xc = ext(cfg.lower_bound);

    mul_a = '0;
    mul_b = '0;
    case (st)
      S_DISP: begin
        if (phase == PH_BR_R) begin
          mul_a = (fin > lv) ? GOLD : ONE - GOLD;
          mul_b = ext(rp) - ext(lp);
        end else begin
          mul_a = tolw;
          mul_b = ext(rp) + ext(lp);
        end
      end
      S_BODY0: begin
        case (bc)
          BC_INIT: begin mul_a = GOLD; mul_b = ext(rp) - ext(lp); end
          BC_R:    begin mul_a = EXPG; mul_b = ext(rp) - ext(mp); end
          BC_M:    begin mul_a = GOLD; mul_b = ext(mp) - ext(lp); end
          default: begin mul_a = EXPG; mul_b = ext(lp) - ext(mp); end
        endcase
      end
      S_IT1:   begin mul_a = tolw; mul_b = ma; end
      S_P0:    begin mul_a = tolw; mul_b = absw(ext(mp)); end
      S_P1:    begin mul_a = ext(mp) - ext(wp); mul_b = ext(mv) - ext(vv); end
      S_P2:    begin mul_a = ext(mp) - ext(vp); mul_b = ext(mv) - ext(wv); end
      S_P3:    begin mul_a = ext(mp) - ext(vp); mul_b = mrw; end
      S_P4:    begin mul_a = ext(mp) - ext(wp); mul_b = ta; end
      S_P6:    begin mul_a = tq; mul_b = ext(eb); end
      S_P7:    begin mul_a = tq; mul_b = wl; end
      S_P8:    begin mul_a = tq; mul_b = wu; end
      S_GOLD0: begin mul_a = GOLD; mul_b = eg; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign div_start = (st == S_P9) && (tq != '0) && c1 && c2 && (tp < mrw);

  // Locals of the step logic.
  logic [32:0]          tol3, stv;
  logic signed [WW-1:0] pv, qv, tlv, uu, twot, dsel, uf;
  logic [7:0]           rc_n;

  always_comb begin
    tol3 = 33'(cfg.tolerance) * 33'd3;
    stv  = (33'(cfg.step_size) > tol3) ? 33'(cfg.step_size) : tol3;
    pv   = tc - mrw;
    qv   = (tb - ta) <<< 1;
    tlv  = tolw + mrw;
    rc_n = rc + 8'd1;
    uu   = ext(mp) + ext(dq);
    twot = tt <<< 1;
    if ((uu - ext(lp) < twot) || (ext(rp) - uu < twot)) dsel = lt ? tt : -tt;
    else dsel = ext(dq);
    if (absw(tc) >= tt) uf = ext(mp) + tc;
    else uf = ext(mp) + ((tc > 0) ? tt : -tt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st    <= S_IDLE;
      ov    <= 1'b0;
      phase <= PH_IDLE;
    end else begin
      if (rsp.valid && rsp.ready) ov <= 1'b0;
      case (st)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            mode_r <= req.mode;
            if (cfg.maximize_mode)
              fin <= (req.function_value == 32'sh80000000) ? 32'sh7fffffff
                                                           : -req.function_value;
            else
              fin <= req.function_value;
            st <= S_DISP;
          end
        end
        S_DISP: begin
          if (!mode_r) begin
            lp    <= '0;
            rp    <= (stv >= 33'h40000000) ? 32'sh7fffffff : $signed({stv[30:0], 1'b0});
            rc    <= '0;
            pp    <= '0;
            phase <= PH_BR_L;
            ov <= 1'b1; ost <= ST_EVAL; opt <= '0; st <= S_IDLE;
          end else begin
            case (phase)
              PH_BR_L: begin
                lv <= fin; pp <= rp; phase <= PH_BR_R;
                ov <= 1'b1; ost <= ST_EVAL; opt <= rp; st <= S_IDLE;
              end
              PH_BR_R: begin rv <= fin; st <= S_BRR1; end
              PH_BR_M: begin mv <= fin; rc <= '0; st <= S_BODY0; end
              PH_NEW_R: begin rv <= fin; st <= S_CHK1; end
              PH_NEW_L: begin lv <= fin; st <= S_CHK1; end
              PH_NEW_M: begin mv <= fin; st <= S_CHK1; end
              PH_INIT_W: begin
                wv <= fin; vv <= fin; dn <= '0; eb <= '0; pp <= mp; phase <= PH_INIT_M;
                ov <= 1'b1; ost <= ST_EVAL; opt <= mp; st <= S_IDLE;
              end
              PH_INIT_M: begin mv <= fin; rc <= '0; phase <= PH_ITER; st <= S_P0; end
              PH_ITER: begin
                // Fold the new sample into the bracket and the two runner-up points.
                if (fin <= mv) begin
                  if (pp < mp) rp <= mp; else lp <= mp;
                  vp <= wp; vv <= wv; wp <= mp; wv <= mv; mp <= pp; mv <= fin;
                end else begin
                  if (pp < mp) lp <= pp; else rp <= pp;
                  if (fin <= wv || wp == mp) begin
                    vp <= wp; vv <= wv; wp <= pp; wv <= fin;
                  end else if (fin <= vv || vp == mp || vp == wp) begin
                    vp <= pp; vv <= fin;
                  end
                end
                st <= S_IT1;
              end
              default: begin
                phase <= PH_IDLE;
                ov <= 1'b1; ost <= ST_IGNORED; opt <= '0; st <= S_IDLE;
              end
            endcase
          end
        end
        S_BRR1: begin
          mp <= sat32(ext(lp) + mrw); pp <= sat32(ext(lp) + mrw); phase <= PH_BR_M;
          ov <= 1'b1; ost <= ST_EVAL; opt <= sat32(ext(lp) + mrw); st <= S_IDLE;
        end
        S_CHK1: begin
          if (ext(rp) - ext(lp) < half(mrw)) begin
            phase <= PH_IDLE;
            ov <= 1'b1; ost <= ST_COLLAPSE; opt <= '0; st <= S_IDLE;
          end else begin
            rc <= rc_n;
            if (rc_n >= 8'(MAX_ROUNDS)) begin
              phase <= PH_IDLE;
              ov <= 1'b1; ost <= ST_BRLIMIT; opt <= '0; st <= S_IDLE;
            end else begin
              st <= S_BODY0;
            end
          end
        end
        S_BODY0: begin
          bcase <= bc;
          case (bc)
            BC_R: begin lp <= mp; lv <= mv; mp <= rp; mv <= rv; end
            BC_M: begin rp <= mp; rv <= mv; end
            BC_L: begin rp <= mp; rv <= mv; mp <= lp; mv <= lv; end
            default: ;
          endcase
          st <= S_BODY1;
        end
        S_BODY1: begin
          case (bcase)
            BC_INIT: begin
              wp <= sat32(body_xc); vp <= sat32(body_xc); phase <= PH_INIT_W;
            end
            BC_R: begin rp <= sat32(body_xc); phase <= PH_NEW_R; end
            BC_M: begin mp <= sat32(body_xc); phase <= PH_NEW_M; end
            default: begin lp <= sat32(body_xc); phase <= PH_NEW_L; end
          endcase
          pp <= sat32(body_xc);
          ov <= 1'b1; ost <= ST_EVAL; opt <= sat32(body_xc); st <= S_IDLE;
        end
        S_IT1: begin
          if (lp > rp) begin
            phase <= PH_IDLE;
            ov <= 1'b1; ost <= ST_INVERTED; opt <= '0; st <= S_IDLE;
          end else begin
            st <= S_IT2;
          end
        end
        S_IT2: begin
          if (ext(rp) - ext(lp) < (tlv <<< 2)) begin
            phase <= PH_IDLE;
            ov <= 1'b1; ost <= ST_DONE; opt <= mp; st <= S_IDLE;
          end else begin
            rc <= rc_n;
            if (rc_n >= 8'(MAX_ROUNDS)) begin
              phase <= PH_IDLE;
              ov <= 1'b1; ost <= ST_ITLIMIT; opt <= '0; st <= S_IDLE;
            end else begin
              st <= S_P0;
            end
          end
        end
        S_P0: st <= S_P1;
        S_P1: begin
          tt <= tlv;
          // A parabolic fit is tried only once the step two rounds back is large enough.
          st <= (absw(ext(eb)) > tlv) ? S_P2 : S_GOLD0;
        end
        S_P2: begin ta <= mrw; st <= S_P3; end
        S_P3: begin tb <= mrw; st <= S_P4; end
        S_P4: begin tc <= mrw; st <= S_P5; end
        S_P5: begin
          if (qv > 0) begin tp <= -pv; tq <= qv; end
          else begin tp <= pv; tq <= -qv; end
          st <= S_P6;
        end
        S_P6: st <= S_P7;
        S_P7: begin c1 <= absw(tp) < absw(half(mrw)); st <= S_P8; end
        S_P8: begin c2 <= tp < mrw; st <= S_P9; end
        S_P9: st <= div_start ? S_DIVW : S_GOLD0;
        S_DIVW: begin
          if (div_done) begin
            tc <= dsel;
            ta <= ext(dn);
            st <= S_FIN;
          end
        end
        S_GOLD0: begin ta <= eg; st <= S_GOLD1; end
        S_GOLD1: begin tc <= mrw; st <= S_FIN; end
        S_FIN: begin
          eb <= sat32(ta);
          dn <= sat32(tc);
          pp <= sat32(uf);
          ov <= 1'b1; ost <= ST_EVAL; opt <= sat32(uf); st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/brent_line_minimizer.sv
// Top level of the Brent line minimizer: configuration registers and the sequencer.
// Depends on blm_pkg, blm_in_if, blm_out_if and blm_seq.
//
// The block searches for the minimum of a function on a line in a dialogue with
// an outside evaluator: a start item (mode 0) begins a search, the block answers
// with a point to evaluate, and each later item (mode 1) brings f at that point.
// Every item gets exactly one result, and no new item is taken until that result
// has been transferred. A Brent step takes the golden-section path, or tries a
// parabolic fit and, if it is rejected, falls back to the golden section, or takes
// a parabolic step, whose quotient comes from a bit-serial divider that produces
// one bit of 32 + FRAC_BITS per cycle. All products share one registered multiplier.
// Configuration registers are written through cfg_we, cfg_index and cfg_data.
`default_nettype none
module brent_line_minimizer
  import blm_pkg::*;
#(
  parameter int MAX_ROUNDS = 30,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  blm_in_if.sink                      req,
  blm_out_if.source                   rsp,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [31:0]            cfg_data
);
  blm_cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tolerance          <= 31'd655;
      cfg.step_size          <= 31'd65536;
      cfg.lower_bound        <= '0;
      cfg.lower_bound_enable <= 1'b0;
      cfg.upper_bound        <= '0;
      cfg.upper_bound_enable <= 1'b0;
      cfg.maximize_mode      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOLERANCE: cfg.tolerance          <= cfg_data[30:0];
        REG_STEP_SIZE: cfg.step_size          <= cfg_data[30:0];
        REG_LOWER:     cfg.lower_bound        <= $signed(cfg_data);
        REG_LOWER_EN:  cfg.lower_bound_enable <= cfg_data[0];
        REG_UPPER:     cfg.upper_bound        <= $signed(cfg_data);
        REG_UPPER_EN:  cfg.upper_bound_enable <= cfg_data[0];
        REG_MAXIMIZE:  cfg.maximize_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  blm_seq #(.MAX_ROUNDS(MAX_ROUNDS), .FRAC_BITS(FRAC_BITS)) u_seq (
    .clk(clk), .rst(rst), .cfg(cfg), .req(req), .rsp(rsp)
  );
endmodule
`default_nettype wire

>>> design/blm_checker.sv
// Port-level checker of the line minimizer, bound to the top level.
// Depends on blm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module blm_checker
  import blm_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               req_valid,
  input wire logic               req_ready,
  input wire logic               rsp_valid,
  input wire logic               rsp_ready,
  input wire logic        [2:0]  rsp_status,
  input wire logic signed [31:0] rsp_point
);
  // One item at a time: after a transfer in, the input side closes.
  `BLM_ASSERT_NEXT(a_one_item, clk, rst, req_valid && req_ready, !req_ready)
  // A pending result keeps the input side closed.
  `BLM_ASSERT_NOW(a_no_overlap, clk, rst, rsp_valid, !req_ready)
  // Error and ignore results carry a zero point.
  `BLM_ASSERT_NOW(a_err_point, clk, rst, rsp_valid && rsp_status != ST_EVAL && rsp_status != ST_DONE, rsp_point == 32'sd0)
  `BLM_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_point))
endmodule

bind brent_line_minimizer blm_checker u_blm_checker (
  .clk(clk), .rst(rst),
  .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .rsp_status(rsp.status), .rsp_point(rsp.point)
);
`default_nettype wire
